FILE: sv/lzwbe_pkg.sv
// lzwbe_pkg: shared constants for the LZW byte encoder.
// No dependencies; used by the cell and the top level.
package lzwbe_pkg;

	localparam int CODE_BITS_DEF = 12;	// widest code in the dictionary
	localparam int CELLS         = 64;	// dictionary banks, one per cell
	localparam int CELL_BITS     = $clog2(CELLS);
	localparam int BYTE_BITS     = 8;
	localparam int CODE_W        = 12;	// code field of a result word
	localparam int CWIDTH_W      = 4;	// code_width field of a result word
	localparam int FIRST_CODE    = 256;	// lowest dictionary code
	localparam int RESET_NEXT    = 255;
	localparam int START_WIDTH   = 8;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_MISS = 4'b0100,
		ST_EOS  = 4'b1000
	} state_t;

endpackage

FILE: sv/lzwbe_if.sv
// lzwbe_if: valid/ready channels for input bytes and output codes.
// Depends on lzwbe_pkg for field widths.
interface lzwbe_byte_if;
	logic                             valid;
	logic                             ready;
	logic [lzwbe_pkg::BYTE_BITS-1:0]  data_byte;
	logic                             last_byte;
	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface lzwbe_code_if;
	logic                             valid;
	logic                             ready;
	logic [lzwbe_pkg::CODE_W-1:0]     code;
	logic [lzwbe_pkg::CWIDTH_W-1:0]   code_width;
	logic                             end_of_stream;
	modport source (output valid, code, code_width, end_of_stream, input ready);
	modport sink   (input valid, code, code_width, end_of_stream, output ready);
endinterface

FILE: sv/lzwbe_cell.sv
// lzwbe_cell: one dictionary bank with its key compare and one stage of the hit chain.
// Depends on lzwbe_pkg.
module lzwbe_cell #(
	parameter int CODE_BITS = lzwbe_pkg::CODE_BITS_DEF,
	parameter int IDX       = 0
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     rd_en,
	input  logic [CODE_BITS-lzwbe_pkg::CELL_BITS-1:0] rd_addr,
	input  logic [CODE_BITS+lzwbe_pkg::BYTE_BITS-1:0] key,
	input  logic                                     wr_en,
	input  logic [CODE_BITS-lzwbe_pkg::CELL_BITS-1:0] wr_addr,
	input  logic [CODE_BITS+lzwbe_pkg::BYTE_BITS-1:0] wr_key,
	input  logic [CODE_BITS-1:0]                     limit,
	input  logic                                     wrapped,
	input  logic                                     chain_found,
	input  logic [CODE_BITS-1:0]                     chain_code,
	output logic                                     found_q,
	output logic [CODE_BITS-1:0]                     code_q
);
	localparam int AB    = CODE_BITS - lzwbe_pkg::CELL_BITS;
	localparam int DEPTH = 2 ** AB;
	localparam int KW    = CODE_BITS + lzwbe_pkg::BYTE_BITS;
	localparam logic [lzwbe_pkg::CELL_BITS-1:0] IDX_V = IDX[lzwbe_pkg::CELL_BITS-1:0];

	logic [KW-1:0]        mem [DEPTH];
	logic [KW-1:0]        rdata_s1;
	logic [AB-1:0]        addr_s1;
	logic                 rd_s1;
	logic [CODE_BITS-1:0] code_s1;
	logic                 entry_ok;
	logic                 match;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_key;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
		addr_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
		end
	end

	// only codes already handed out in this stream count
	assign code_s1  = {addr_s1, IDX_V};
	assign entry_ok = (code_s1[CODE_BITS-1:8] != '0) && (wrapped || code_s1 <= limit);
	assign match    = rd_s1 && entry_ok && (rdata_s1 == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else begin
			found_q <= match | chain_found;
		end
	end

	always_ff @(posedge clk) begin
		code_q <= match ? code_s1 : chain_code;
	end

endmodule

FILE: sv/lzw_byte_encoder_top.sv
// lzw_byte_encoder_top: streaming LZW encoder, one byte word in, up to two code words out.
// A byte that needs a lookup scans the dictionary before its result words go out; the first
// byte of a stream only becomes the prefix. A new byte is accepted only in ST_IDLE, after the
// previous byte's scan and result words are done. The scan sweeps all 64 banks in parallel,
// one address a cycle, and the hit travels down the 64-cell chain. Asynchronous reset (arst_n
// low) clears the stream state; the dictionary memories need no clearing pass.
module lzw_byte_encoder_top #(
	parameter int CODE_BITS = lzwbe_pkg::CODE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	lzwbe_byte_if.sink    bytes,
	lzwbe_code_if.source  codes
);
	localparam int CB       = lzwbe_pkg::CELL_BITS;
	localparam int NC       = lzwbe_pkg::CELLS;
	localparam int AB       = CODE_BITS - CB;
	localparam int DEPTH    = 2 ** AB;
	localparam int KW       = CODE_BITS + lzwbe_pkg::BYTE_BITS;
	localparam int WW       = $clog2(CODE_BITS + 1);
	localparam int SCAN_END = DEPTH + NC + 2;
	localparam int CNTW     = $clog2(SCAN_END + 1);
	localparam logic [CNTW-1:0] CNT_END   = CNTW'(SCAN_END);
	localparam logic [CNTW-1:0] CNT_DEPTH = CNTW'(DEPTH);

	lzwbe_pkg::state_t state_q;

	// stream state
	logic [CODE_BITS-1:0] prefix_q;
	logic                 prefix_valid_q;
	logic [CODE_BITS-1:0] next_q;		// last code handed out
	logic [WW-1:0]        width_q;
	logic                 wrapped_q;	// every dictionary code in use

	logic [7:0]           byte_q;
	logic                 last_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 hit_q;
	logic [CODE_BITS-1:0] hit_code_q;
	logic [CODE_BITS-1:0] miss_code_q;

	// hit chain taps
	logic                 chain_found [NC+1];
	logic [CODE_BITS-1:0] chain_code  [NC+1];

	logic                 rd_en;
	logic [AB-1:0]        rd_addr;
	logic [KW-1:0]        key;
	logic                 wr_en;
	logic [CODE_BITS:0]   top;
	logic [CODE_BITS-1:0] next_new;
	logic [WW-1:0]        width_new;
	logic                 wrap_new;
	logic                 deciding;

	assign key      = {prefix_q, byte_q};
	assign rd_en    = (state_q == lzwbe_pkg::ST_SCAN) && (cnt_q < CNT_DEPTH);
	assign rd_addr  = cnt_q[AB-1:0];
	assign deciding = (state_q == lzwbe_pkg::ST_SCAN) && (cnt_q == CNT_END);
	assign wr_en    = deciding && !hit_q;

	// next code assignment on a miss
	always_comb begin
		top       = ({{CODE_BITS{1'b0}}, 1'b1} << width_q) - 1'b1;
		next_new  = next_q + 1'b1;
		width_new = width_q;
		wrap_new  = wrapped_q;
		if ({1'b0, next_q} == top) begin
			if (width_q >= WW'(CODE_BITS)) begin
				next_new = CODE_BITS'(lzwbe_pkg::FIRST_CODE);
				wrap_new = 1'b1;
			end else begin
				width_new = width_q + 1'b1;
			end
		end
	end

	assign chain_found[0] = 1'b0;
	assign chain_code[0]  = '0;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		lzwbe_cell #(
			.CODE_BITS(CODE_BITS),
			.IDX(k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.rd_en      (rd_en),
			.rd_addr    (rd_addr),
			.key        (key),
			.wr_en      (wr_en && (next_new[CB-1:0] == CB'(k))),
			.wr_addr    (next_new[CODE_BITS-1:CB]),
			.wr_key     (key),
			.limit      (next_q),
			.wrapped    (wrapped_q),
			.chain_found(chain_found[k]),
			.chain_code (chain_code[k]),
			.found_q    (chain_found[k+1]),
			.code_q     (chain_code[k+1])
		);
	end

	assign bytes.ready = (state_q == lzwbe_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= lzwbe_pkg::ST_IDLE;
			prefix_q       <= '0;
			prefix_valid_q <= 1'b0;
			next_q         <= CODE_BITS'(lzwbe_pkg::RESET_NEXT);
			width_q        <= WW'(lzwbe_pkg::START_WIDTH);
			wrapped_q      <= 1'b0;
			cnt_q          <= '0;
			hit_q          <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			case (state_q)
				lzwbe_pkg::ST_IDLE: begin
					if (bytes.valid) begin
						last_q <= bytes.last_byte;
						cnt_q  <= '0;
						hit_q  <= 1'b0;
						if (!prefix_valid_q) begin
							// first byte of a stream becomes the prefix
							prefix_q       <= CODE_BITS'(bytes.data_byte);
							prefix_valid_q <= 1'b1;
							if (bytes.last_byte) begin
								state_q <= lzwbe_pkg::ST_EOS;
							end
						end else begin
							state_q <= lzwbe_pkg::ST_SCAN;
						end
					end
				end
				lzwbe_pkg::ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (chain_found[NC]) begin
						hit_q <= 1'b1;
					end
					if (deciding) begin
						if (hit_q) begin
							prefix_q <= hit_code_q;
							state_q  <= last_q ? lzwbe_pkg::ST_EOS : lzwbe_pkg::ST_IDLE;
						end else begin
							next_q    <= next_new;
							width_q   <= width_new;
							wrapped_q <= wrap_new;
							prefix_q  <= CODE_BITS'(byte_q);
							state_q   <= lzwbe_pkg::ST_MISS;
						end
					end
				end
				lzwbe_pkg::ST_MISS: begin
					if (codes.ready) begin
						state_q <= last_q ? lzwbe_pkg::ST_EOS : lzwbe_pkg::ST_IDLE;
					end
				end
				lzwbe_pkg::ST_EOS: begin
					if (codes.ready) begin
						// stream closed: back to an empty dictionary
						prefix_q       <= '0;
						prefix_valid_q <= 1'b0;
						next_q         <= CODE_BITS'(lzwbe_pkg::RESET_NEXT);
						width_q        <= WW'(lzwbe_pkg::START_WIDTH);
						wrapped_q      <= 1'b0;
						state_q        <= lzwbe_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lzwbe_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_q <= bytes.data_byte;
		end
		if (state_q == lzwbe_pkg::ST_SCAN && chain_found[NC]) begin
			hit_code_q <= chain_code[NC];
		end
		if (deciding) begin
			miss_code_q <= prefix_q;
		end
	end

	logic [CODE_BITS-1:0] out_code;
	logic [CODE_BITS+lzwbe_pkg::CODE_W-1:0] out_code_x;
	logic [WW+lzwbe_pkg::CWIDTH_W-1:0]      out_width_x;

	assign out_code    = (state_q == lzwbe_pkg::ST_MISS) ? miss_code_q : prefix_q;
	assign out_code_x  = {{lzwbe_pkg::CODE_W{1'b0}}, out_code};
	assign out_width_x = {{lzwbe_pkg::CWIDTH_W{1'b0}}, width_q};

	assign codes.valid         = (state_q == lzwbe_pkg::ST_MISS) || (state_q == lzwbe_pkg::ST_EOS);
	assign codes.code          = out_code_x[lzwbe_pkg::CODE_W-1:0];
	assign codes.code_width    = out_width_x[lzwbe_pkg::CWIDTH_W-1:0];
	assign codes.end_of_stream = (state_q == lzwbe_pkg::ST_EOS);

	// a lookup only runs with a prefix held
	a_scan_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lzwbe_pkg::ST_SCAN) |-> prefix_valid_q)
		else $error("scan without prefix");

	// a hit always names a dictionary code
	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		(deciding && hit_q) |-> (hit_code_q[CODE_BITS-1:8] != '0))
		else $error("hit on a byte code");

	// once the width has grown, the last code handed out is a dictionary code
	a_next_range: assert property (@(posedge clk) disable iff (!arst_n)
		(width_q > WW'(lzwbe_pkg::START_WIDTH)) |-> (next_q[CODE_BITS-1:8] != '0))
		else $error("next code out of range");

	// width never passes the widest code
	a_width_max: assert property (@(posedge clk) disable iff (!arst_n)
		width_q <= WW'(CODE_BITS))
		else $error("code width overflow");

endmodule

FILE: tb/sv/tb_lzwbe_chan_if.sv
`timescale 1ns / 1ps
// tb_lzwbe_chan_if: bench package with the packed byte and code word types.
// Depends on lzwbe_pkg.
package tb_lzwbe_pkg;

	typedef struct packed {
		logic [lzwbe_pkg::BYTE_BITS-1:0] data_byte;
		logic                            last_byte;
	} byte_word_t;

	typedef struct packed {
		logic [lzwbe_pkg::CODE_W-1:0]   code;
		logic [lzwbe_pkg::CWIDTH_W-1:0] code_width;
		logic                           end_of_stream;
	} code_word_t;
endpackage

FILE: tb/sv/tb_lzw_byte_encoder_top.sv
`timescale 1ns / 1ps
// tb_lzw_byte_encoder_top: self-checking bench for the LZW byte encoder.
// Depends on lzwbe_pkg, lzwbe_if.sv, tb_lzwbe_pkg and lzw_byte_encoder_top.
module tb_lzw_byte_encoder_top;

	localparam int DICT_N    = 1 << lzwbe_pkg::CODE_BITS_DEF;
	localparam int WDOG_MAX  = 20000;	// idle cycles: the scan plus long receiver stalls
	localparam int DRAIN_CYC = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lzwbe_byte_if bytes ();
	lzwbe_code_if codes ();

	lzw_byte_encoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.codes  (codes)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// encoder model state
	logic [11:0] lz_prefix;
	logic        lz_have_prefix;
	logic [11:0] lz_next;
	logic [3:0]  lz_width;
	logic [19:0] lz_pairs [DICT_N];
	logic        lz_used  [DICT_N];

	tb_lzwbe_pkg::byte_word_t byte_queue[$];
	tb_lzwbe_pkg::code_word_t code_queue[$];
	int         fail_count = 0;
	int         send_idle_pct = 21;
	int         recv_idle_pct = 49;
	bit         hold_send = 1'b0;
	bit         stim_done = 1'b0;
	int         wdog = 0;

	task automatic report(input string what, input tb_lzwbe_pkg::code_word_t got,
		input tb_lzwbe_pkg::code_word_t want);
		$display("mismatch %s: got code %0d width %0d eos %0b, want %0d %0d %0b", what,
			got.code, got.code_width, got.end_of_stream,
			want.code, want.code_width, want.end_of_stream);
		fail_count++;
	endtask

	function automatic void stream_clear();
		lz_prefix      = '0;
		lz_have_prefix = 1'b0;
		lz_next        = 12'(lzwbe_pkg::RESET_NEXT);
		lz_width       = 4'(lzwbe_pkg::START_WIDTH);
		foreach (lz_used[i]) lz_used[i] = 1'b0;
	endfunction

	function automatic void queue_byte(input logic [7:0] d, input logic l);
		tb_lzwbe_pkg::byte_word_t w;
		w.data_byte = d;
		w.last_byte = l;
		byte_queue.insert(byte_queue.size(), w);
	endfunction

	// Advance the model by one byte and queue the codes it yields.
	function automatic void encode_byte(input tb_lzwbe_pkg::byte_word_t w);
		logic [11:0] hit;
		logic [19:0] key;
		int          top;
		tb_lzwbe_pkg::code_word_t c;
		hit = '0;
		if (!lz_have_prefix) begin
			lz_prefix      = 12'(w.data_byte);
			lz_have_prefix = 1'b1;
		end else begin
			key = {lz_prefix, w.data_byte};
			for (int i = lzwbe_pkg::FIRST_CODE; i < DICT_N; i++)
				if (lz_used[i] && lz_pairs[i] == key) begin
					hit = 12'(i);
					break;
				end
			if (hit != 0) begin
				lz_prefix = hit;
			end else begin
				top = (1 << lz_width) - 1;
				if (int'(lz_next) == top) begin
					if (lz_width >= 4'(lzwbe_pkg::CODE_BITS_DEF))
						lz_next = 12'(lzwbe_pkg::FIRST_CODE);
					else begin
						lz_width++;
						lz_next++;
					end
				end else begin
					lz_next++;
				end
				if (lz_next < 12'(lzwbe_pkg::FIRST_CODE)) lz_next = 12'(lzwbe_pkg::FIRST_CODE);
				c.code = lz_prefix; c.code_width = lz_width; c.end_of_stream = 1'b0;
				code_queue.insert(code_queue.size(), c);
				lz_pairs[lz_next] = key;
				lz_used[lz_next]  = 1'b1;
				lz_prefix = 12'(w.data_byte);
			end
		end
		if (w.last_byte) begin
			c.code = lz_prefix; c.code_width = lz_width; c.end_of_stream = 1'b1;
			code_queue.insert(code_queue.size(), c);
			stream_clear();
		end
	endfunction

	// Driver: words leave the pending queue, the model sees them on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes.valid     <= 1'b0;
			bytes.data_byte <= '0;
			bytes.last_byte <= 1'b0;
		end else begin
			if (bytes.valid && bytes.ready)
				encode_byte({bytes.data_byte, bytes.last_byte});
			if ((!bytes.valid || bytes.ready) ) begin
				if (byte_queue.size() != 0 && !hold_send &&
				    $urandom_range(99) >= send_idle_pct) begin
					bytes.valid <= 1'b1;
					{bytes.data_byte, bytes.last_byte} <= byte_queue.pop_front();
				end else begin
					bytes.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes.ready <= 1'b0;
		end else begin
			if (codes.valid && codes.ready) begin
				tb_lzwbe_pkg::code_word_t got;
				got = {codes.code, codes.code_width, codes.end_of_stream};
				if (code_queue.size() == 0) begin
					report("unexpected word", got, got);
				end else begin
					tb_lzwbe_pkg::code_word_t want;
					want = code_queue.pop_front();
					if (got.code != want.code) report("code", got, want);
					if (got.code_width != want.code_width) report("code_width", got, want);
					if (got.end_of_stream != want.end_of_stream) report("end_of_stream", got, want);
				end
			end
			codes.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: cycles with no word accepted on either side.
	always @(posedge clk) begin
		if ((bytes.valid && bytes.ready) || (codes.valid && codes.ready) || !arst_n)
			wdog <= 0;
		else if (byte_queue.size() != 0 || code_queue.size() != 0 || !stim_done)
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add_stream(input int len, input int alpha);
		logic [7:0] d;
		for (int i = 0; i < len; i++) begin
			d = (alpha >= 256) ? 8'($urandom) : 8'($urandom_range(alpha - 1));
			queue_byte(d, (i == len - 1));
		end
	endtask

	task automatic wait_drained();
		while (byte_queue.size() != 0 || bytes.valid || code_queue.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		stream_clear();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: single byte streams at the extremes, repeats for hits
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hFF, 1'b1);
		for (int i = 0; i < 8; i++) queue_byte(8'hAA, 1'b0);
		queue_byte(8'h55, 1'b1);
		for (int i = 0; i < 6; i++) queue_byte(((i % 2) != 0) ? 8'hFF : 8'h00, 1'b0);
		queue_byte(8'h00, 1'b1);

		// pause: wait until every code has arrived, then hold the sender idle
		wait_drained();
		hold_send = 1'b1;
		repeat (20) @(posedge clk);
		hold_send = 1'b0;

		// random streams, three idling phases; one long stream passes width growth
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 49 : 0;
			recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 21 : 0;
			for (int k = 0; k < 10; k++)
				add_stream($urandom_range(1, 40), ($urandom_range(1) != 0) ? 256 : 4);
			if (ph == 2) add_stream(300, 256);
			wait_drained();
		end
		stim_done = 1'b1;
		repeat (DRAIN_CYC) @(posedge clk);
		if (fail_count == 0 && code_queue.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
